>>> rtl/trpc_pkg.sv
// Shared constants and register map of the torus router output-port calculator.
package trpc_pkg;

	// Fixed field widths
	localparam int ID_W       = 8;   // router id / neighbor id
	localparam int DEST_W     = 10;  // flit destination id
	localparam int OUT_W      = 3;   // selected output port
	localparam int PORT_MAX_W = 6;   // widest table port field allowed

	// Stream widths
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 8;

	// Configuration port
	localparam int CFG_AW   = 6;
	localparam int CFG_DW   = 64;
	localparam int TBL_W    = 48;
	localparam int TBL_SPAN = 64;  // table entries past this span are invalid

	// Register indexes (byte address = 8 * index)
	localparam logic [2:0] REG_ROUTER_ID    = 3'd0;
	localparam logic [2:0] REG_COLUMN_COUNT = 3'd1;
	localparam logic [2:0] REG_ROW_COUNT    = 3'd2;
	localparam logic [2:0] REG_BUFFER_BASE  = 3'd3;
	localparam logic [2:0] REG_CORE_PORT    = 3'd4;
	localparam logic [2:0] REG_BUFFER_PORT  = 3'd5;
	localparam logic [2:0] REG_NEIGHBOR_TBL = 3'd6;

	// Reset values
	localparam logic [7:0]       RST_ROUTER_ID    = 8'd0;
	localparam logic [4:0]       RST_COLUMN_COUNT = 5'd4;
	localparam logic [4:0]       RST_ROW_COUNT    = 5'd4;
	localparam logic [10:0]      RST_BUFFER_BASE  = 11'h7FF;
	localparam logic [3:0]       RST_CORE_PORT    = 4'hF;
	localparam logic [3:0]       RST_BUFFER_PORT  = 4'hF;
	localparam logic [TBL_W-1:0] RST_NEIGHBOR_TBL = '0;

	// Parameter defaults
	localparam int MAX_DIM_DEF        = 16;
	localparam int NEIGHBOR_SLOTS_DEF = 4;
	localparam int PORT_BITS_DEF      = 3;

endpackage

>>> rtl/trpc_split.sv
// Pipelined split of an id into column, row and row-modulo-rows coordinates.
module trpc_split #(
	parameter int MAX_DIM = trpc_pkg::MAX_DIM_DEF
) (
	input  logic                           clk,
	input  logic [3:0]                     en,
	input  logic [trpc_pkg::ID_W-1:0]      value,
	input  logic [$clog2(MAX_DIM+1)-1:0]   cols,
	input  logic [$clog2(MAX_DIM+1)-1:0]   rows,
	output logic [$clog2(MAX_DIM+1)-1:0]   col_rem,
	output logic [trpc_pkg::ID_W-1:0]      quo,
	output logic [$clog2(MAX_DIM+1)-1:0]   row_rem
);
	import trpc_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int REM_W = DIM_W + 1;
	localparam int LO_N  = ID_W / 2;

	logic [DIM_W-1:0] rem_s1, crem_s2, crem_s3, rrem_s3, crem_s4, rrem_s4;
	logic [ID_W-1:0]  num_s1, quo_s1, quo_s2, quo_s3, quo_s4;
	logic [REM_W-1:0] r1, r2, r3, r4;
	logic [REM_W:0]   t1, t2, t3, t4;
	logic [ID_W-1:0]  q1, q2;

	// one restoring step: shift in a bit, subtract when it fits
	function automatic logic [REM_W:0] rem_step(input logic [REM_W-1:0] r, input logic b,
			input logic [DIM_W-1:0] d);
		logic [REM_W-1:0] t;
		t = {r[REM_W-2:0], b};
		if (t >= REM_W'(d))
			return {1'b1, t - REM_W'(d)};
		return {1'b0, t};
	endfunction

	// upper quotient bits by cols
	always_comb begin
		r1 = '0;
		q1 = '0;
		t1 = '0;
		for (int i = ID_W - 1; i >= LO_N; i--) begin
			t1    = rem_step(r1, value[i], cols);
			q1[i] = t1[REM_W];
			r1    = t1[REM_W-1:0];
		end
	end

	// lower quotient bits by cols
	always_comb begin
		r2 = REM_W'(rem_s1);
		q2 = quo_s1;
		t2 = '0;
		for (int i = LO_N - 1; i >= 0; i--) begin
			t2    = rem_step(r2, num_s1[i], cols);
			q2[i] = t2[REM_W];
			r2    = t2[REM_W-1:0];
		end
	end

	// quotient modulo rows, upper bits
	always_comb begin
		r3 = '0;
		t3 = '0;
		for (int i = ID_W - 1; i >= LO_N; i--) begin
			t3 = rem_step(r3, quo_s2[i], rows);
			r3 = t3[REM_W-1:0];
		end
	end

	// quotient modulo rows, lower bits
	always_comb begin
		r4 = REM_W'(rrem_s3);
		t4 = '0;
		for (int i = LO_N - 1; i >= 0; i--) begin
			t4 = rem_step(r4, quo_s3[i], rows);
			r4 = t4[REM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s1 <= r1[DIM_W-1:0];
			quo_s1 <= q1;
			num_s1 <= value;
		end
		if (en[1]) begin
			crem_s2 <= r2[DIM_W-1:0];
			quo_s2  <= q2;
		end
		if (en[2]) begin
			rrem_s3 <= r3[DIM_W-1:0];
			crem_s3 <= crem_s2;
			quo_s3  <= quo_s2;
		end
		if (en[3]) begin
			rrem_s4 <= r4[DIM_W-1:0];
			crem_s4 <= crem_s3;
			quo_s4  <= quo_s3;
		end
	end

	assign col_rem = crem_s4;
	assign quo     = quo_s4;
	assign row_rem = rrem_s4;

endmodule

>>> rtl/torus_router_output_port_calc.sv
// Top level of the torus router output-port calculator.
//
// Use: one beat on the s_ side carries a flit's destination id and the
// logical next hop from the topology manager; one beat on the m_ side
// returns the switch output port and a dead-end flag for it, in order.
// Registers (router id, grid size, buffer base, core/buffer ports, neighbor
// table) sit at byte address 8 * index on the APB port; the user must write them
// only while no beat is in flight, as the block does not enforce it; pready is
// tied high and reads return the raw value. Throughput: one beat per cycle
// unless m_tready stalls the output. Four stages split each id into torus
// coordinates in a restoring divider (four quotient bits a stage, first by
// columns, then the row by rows); one stage forms the torus step, buffer hop
// and distance per table slot; one stage does the table lookups and
// nearest-neighbor pick; the last stage is the output register.
// Reset clears all valid bits and loads the register reset values.
// Each stage holds when the stage ahead is full and stalled, so a stall on
// m_tready backs up only as far as needed; s_tready stays high while any
// bubble remains in the pipeline.
module torus_router_output_port_calc #(
	parameter int MAX_DIM        = trpc_pkg::MAX_DIM_DEF,
	parameter int NEIGHBOR_SLOTS = trpc_pkg::NEIGHBOR_SLOTS_DEF,
	parameter int PORT_BITS      = trpc_pkg::PORT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [trpc_pkg::CFG_AW-1:0]       paddr,
	input  logic [trpc_pkg::CFG_DW-1:0]       pwdata,
	output logic [trpc_pkg::CFG_DW-1:0]       prdata,
	output logic                              pready,
	// input beats
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [trpc_pkg::S_TDATA_W-1:0]    s_tdata,   // dest_id[9:0], logical_hop[17:10]
	// result beats
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [trpc_pkg::M_TDATA_W-1:0]    m_tdata,   // out_port[2:0]
	output logic                              m_tuser    // dead_end[0]
);
	import trpc_pkg::*;

	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int XW     = DIM_W + 1;
	localparam int NS     = NEIGHBOR_SLOTS;
	localparam int EB     = PORT_BITS + 9;
	localparam int STEP_W = (ID_W + 1 > 2 * DIM_W) ? ID_W + 1 : 2 * DIM_W;

	typedef struct packed {
		logic             is_me;
		logic             is_buf;
		logic [DIM_W-1:0] brow;
		logic             hop_hit;
		logic [OUT_W-1:0] hop_port;
		logic [ID_W-1:0]  hop;
	} side_t;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [7:0]       router_id_q;
	logic [4:0]       column_count_q;
	logic [4:0]       row_count_q;
	logic [10:0]      buffer_base_q;
	logic [3:0]       core_port_q;
	logic [3:0]       buffer_port_q;
	logic [TBL_W-1:0] neighbor_table_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			router_id_q      <= RST_ROUTER_ID;
			column_count_q   <= RST_COLUMN_COUNT;
			row_count_q      <= RST_ROW_COUNT;
			buffer_base_q    <= RST_BUFFER_BASE;
			core_port_q      <= RST_CORE_PORT;
			buffer_port_q    <= RST_BUFFER_PORT;
			neighbor_table_q <= RST_NEIGHBOR_TBL;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				REG_ROUTER_ID:    router_id_q      <= pwdata[7:0];
				REG_COLUMN_COUNT: column_count_q   <= pwdata[4:0];
				REG_ROW_COUNT:    row_count_q      <= pwdata[4:0];
				REG_BUFFER_BASE:  buffer_base_q    <= pwdata[10:0];
				REG_CORE_PORT:    core_port_q      <= pwdata[3:0];
				REG_BUFFER_PORT:  buffer_port_q    <= pwdata[3:0];
				REG_NEIGHBOR_TBL: neighbor_table_q <= pwdata[TBL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			REG_ROUTER_ID:    prdata = CFG_DW'(router_id_q);
			REG_COLUMN_COUNT: prdata = CFG_DW'(column_count_q);
			REG_ROW_COUNT:    prdata = CFG_DW'(row_count_q);
			REG_BUFFER_BASE:  prdata = CFG_DW'(buffer_base_q);
			REG_CORE_PORT:    prdata = CFG_DW'(core_port_q);
			REG_BUFFER_PORT:  prdata = CFG_DW'(buffer_port_q);
			REG_NEIGHBOR_TBL: prdata = CFG_DW'(neighbor_table_q);
			default:          prdata = '0;
		endcase
	end

	// Grid size, zero taken as one and clipped to MAX_DIM
	logic [DIM_W-1:0] cols_w, rows_w;

	always_comb begin
		if (column_count_q == '0)
			cols_w = DIM_W'(1);
		else if (int'(column_count_q) > MAX_DIM)
			cols_w = DIM_W'(MAX_DIM);
		else
			cols_w = DIM_W'(column_count_q);
		if (row_count_q == '0)
			rows_w = DIM_W'(1);
		else if (int'(row_count_q) > MAX_DIM)
			rows_w = DIM_W'(MAX_DIM);
		else
			rows_w = DIM_W'(row_count_q);
	end

	// Neighbor table slots; a slot reaching past the 64-bit span is invalid
	logic [TBL_SPAN-1:0]  tbl_w;
	logic [NS-1:0]        slot_vld;
	logic [ID_W-1:0]      slot_nid  [NS];
	logic [PORT_BITS-1:0] slot_port [NS];

	assign tbl_w = TBL_SPAN'(neighbor_table_q);

	for (genvar s = 0; s < NS; s++) begin : g_slot
		if ((s + 1) * EB <= TBL_SPAN) begin : g_fit
			assign slot_vld[s]  = tbl_w[s*EB + EB - 1];
			assign slot_nid[s]  = tbl_w[s*EB + PORT_BITS +: ID_W];
			assign slot_port[s] = tbl_w[s*EB +: PORT_BITS];
		end else begin : g_past
			assign slot_vld[s]  = 1'b0;
			assign slot_nid[s]  = '0;
			assign slot_port[s] = '0;
		end
	end

	function automatic logic [OUT_W-1:0] to_out(input logic [PORT_BITS-1:0] p);
		logic [PORT_MAX_W-1:0] e;
		e = PORT_MAX_W'(p);
		return e[OUT_W-1:0];
	endfunction

	// ---------------------------------------------------------------
	// Stage enables: a stage loads when empty or when the next one moves
	// ---------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;

	assign adv7 = !v_s7 || m_tready;
	assign adv6 = !v_s6 || adv7;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;

	assign s_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= s_tvalid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
			if (adv7) v_s7 <= v_s6;
		end
	end

	// ---------------------------------------------------------------
	// Entry: destination class and direct lookup of the logical hop
	// ---------------------------------------------------------------
	logic [DEST_W-1:0] dest_w;
	logic [ID_W-1:0]   hop_w;
	logic [10:0]       bb_w;
	side_t             side_w;

	assign dest_w = s_tdata[DEST_W-1:0];
	assign hop_w  = s_tdata[DEST_W +: ID_W];
	assign bb_w   = {1'b0, buffer_base_q[9:0]};

	always_comb begin
		side_w.is_me  = (dest_w == DEST_W'(router_id_q));
		side_w.is_buf = !buffer_base_q[10] && (11'(dest_w) >= bb_w) &&
			(11'(dest_w) < bb_w + 11'(rows_w));
		side_w.brow   = DIM_W'(11'(dest_w) - bb_w);
		side_w.hop    = hop_w;
		side_w.hop_hit  = 1'b0;
		side_w.hop_port = '0;
		// scan downward so the lowest matching slot wins
		for (int s = NS - 1; s >= 0; s--) begin
			if (slot_vld[s] && slot_nid[s] == hop_w) begin
				side_w.hop_hit  = 1'b1;
				side_w.hop_port = to_out(slot_port[s]);
			end
		end
	end

	// ---------------------------------------------------------------
	// Stages 1-4: coordinates of hop, this router and every slot
	// ---------------------------------------------------------------
	side_t side_s1, side_s2, side_s3, side_s4;
	logic [3:0] lane_en;

	assign lane_en = {adv4, adv3, adv2, adv1};

	always_ff @(posedge clk) begin
		if (adv1) side_s1 <= side_w;
		if (adv2) side_s2 <= side_s1;
		if (adv3) side_s3 <= side_s2;
		if (adv4) side_s4 <= side_s3;
	end

	logic [DIM_W-1:0] hop_cr, hop_rr, me_cr, me_rr;
	logic [ID_W-1:0]  hop_q, me_q;
	logic [DIM_W-1:0] sn_cr [NS];
	logic [DIM_W-1:0] sn_rr [NS];

	trpc_split #(.MAX_DIM(MAX_DIM)) u_split_hop (
		.clk     (clk),
		.en      (lane_en),
		.value   (hop_w),
		.cols    (cols_w),
		.rows    (rows_w),
		.col_rem (hop_cr),
		.quo     (hop_q),
		.row_rem (hop_rr)
	);

	trpc_split #(.MAX_DIM(MAX_DIM)) u_split_me (
		.clk     (clk),
		.en      (lane_en),
		.value   (router_id_q),
		.cols    (cols_w),
		.rows    (rows_w),
		.col_rem (me_cr),
		.quo     (me_q),
		.row_rem (me_rr)
	);

	for (genvar s = 0; s < NS; s++) begin : g_split
		trpc_split #(.MAX_DIM(MAX_DIM)) u_split_nb (
			.clk     (clk),
			.en      (lane_en),
			.value   (slot_nid[s]),
			.cols    (cols_w),
			.rows    (rows_w),
			.col_rem (sn_cr[s]),
			.quo     (),
			.row_rem (sn_rr[s])
		);
	end

	// ---------------------------------------------------------------
	// Stage 5: torus step, buffer hop, distance per slot
	// ---------------------------------------------------------------
	logic [XW-1:0]      right_w, down_w;
	logic               xplus_w, yplus_w, xgo_w, ygo_w;
	logic [DIM_W-1:0]   nx_w, ny_w;
	logic [2*DIM_W-1:0] ymul_w;
	logic [STEP_W-1:0]  step_w, buf_id_w;
	logic               buf_local_w;
	logic [XW-1:0]      tdist_w [NS];

	always_comb begin
		// X move: plus direction when it is no longer than minus
		right_w = (hop_cr >= me_cr) ? XW'(hop_cr) - XW'(me_cr)
			: XW'(hop_cr) + XW'(cols_w) - XW'(me_cr);
		xplus_w = {right_w, 1'b0} <= (XW + 1)'(cols_w);
		if (xplus_w)
			nx_w = (XW'(me_cr) + XW'(1) == XW'(cols_w)) ? '0 : me_cr + DIM_W'(1);
		else
			nx_w = (me_cr == '0) ? cols_w - DIM_W'(1) : me_cr - DIM_W'(1);
		xgo_w = (hop_cr != me_cr) && (cols_w > DIM_W'(1));

		// Y move on rows reduced modulo the row count
		down_w = (hop_rr >= me_rr) ? XW'(hop_rr) - XW'(me_rr)
			: XW'(hop_rr) + XW'(rows_w) - XW'(me_rr);
		yplus_w = (down_w == '0) || ({down_w, 1'b0} <= (XW + 1)'(rows_w));
		if (yplus_w)
			ny_w = (XW'(me_rr) + XW'(1) == XW'(rows_w)) ? '0 : me_rr + DIM_W'(1);
		else
			ny_w = (me_rr == '0) ? rows_w - DIM_W'(1) : me_rr - DIM_W'(1);
		ygo_w  = (hop_q != me_q) && (rows_w > DIM_W'(1));
		ymul_w = (2 * DIM_W)'(ny_w) * (2 * DIM_W)'(cols_w);

		if (xgo_w)
			step_w = STEP_W'(router_id_q) - STEP_W'(me_cr) + STEP_W'(nx_w);
		else if (ygo_w)
			step_w = STEP_W'(ymul_w) + STEP_W'(me_cr);
		else
			step_w = STEP_W'(side_s4.hop);

		// buffer route: west to column 0, then toward the buffer row
		buf_local_w = (me_cr == '0) && (me_q == ID_W'(side_s4.brow));
		if (me_cr != '0)
			buf_id_w = STEP_W'(router_id_q) - STEP_W'(1);
		else if (me_q > ID_W'(side_s4.brow))
			buf_id_w = STEP_W'(router_id_q) - STEP_W'(cols_w);
		else
			buf_id_w = STEP_W'(router_id_q) + STEP_W'(cols_w);
	end

	always_comb begin
		logic [XW-1:0] dx, dy, dxm, dym;
		for (int s = 0; s < NS; s++) begin
			dx  = (hop_cr >= sn_cr[s]) ? XW'(hop_cr) - XW'(sn_cr[s])
				: XW'(hop_cr) + XW'(cols_w) - XW'(sn_cr[s]);
			dy  = (hop_rr >= sn_rr[s]) ? XW'(hop_rr) - XW'(sn_rr[s])
				: XW'(hop_rr) + XW'(rows_w) - XW'(sn_rr[s]);
			dxm = (XW'(cols_w) - dx < dx) ? XW'(cols_w) - dx : dx;
			dym = (XW'(rows_w) - dy < dy) ? XW'(rows_w) - dy : dy;
			tdist_w[s] = dxm + dym;
		end
	end

	logic              is_me_s5, is_buf_s5, hop_hit_s5, buf_local_s5;
	logic [OUT_W-1:0]  hop_port_s5;
	logic [STEP_W-1:0] step_s5, buf_id_s5;
	logic [XW-1:0]     tdist_s5 [NS];

	always_ff @(posedge clk) begin
		if (adv5) begin
			is_me_s5     <= side_s4.is_me;
			is_buf_s5    <= side_s4.is_buf;
			hop_hit_s5   <= side_s4.hop_hit;
			hop_port_s5  <= side_s4.hop_port;
			buf_local_s5 <= buf_local_w;
			step_s5      <= step_w;
			buf_id_s5    <= buf_id_w;
			tdist_s5     <= tdist_w;
		end
	end

	// ---------------------------------------------------------------
	// Stage 6: lookups of step and buffer hop, nearest neighbor
	// ---------------------------------------------------------------
	logic             step_hit_w, buf_hit_w, best_hit_w;
	logic [OUT_W-1:0] step_port_w, buf_port_w, best_port_w;
	logic [XW-1:0]    best_d_w;
	logic [ID_W-1:0]  best_nid_w;

	always_comb begin
		step_hit_w  = 1'b0;
		step_port_w = '0;
		buf_hit_w   = 1'b0;
		buf_port_w  = '0;
		for (int s = NS - 1; s >= 0; s--) begin
			if (slot_vld[s] && STEP_W'(slot_nid[s]) == step_s5) begin
				step_hit_w  = 1'b1;
				step_port_w = to_out(slot_port[s]);
			end
			if (slot_vld[s] && STEP_W'(slot_nid[s]) == buf_id_s5) begin
				buf_hit_w  = 1'b1;
				buf_port_w = to_out(slot_port[s]);
			end
		end
	end

	// least distance, then lowest id, then lowest slot
	always_comb begin
		best_hit_w  = 1'b0;
		best_port_w = '0;
		best_d_w    = '0;
		best_nid_w  = '0;
		for (int s = 0; s < NS; s++) begin
			if (slot_vld[s] && (!best_hit_w || tdist_s5[s] < best_d_w ||
					(tdist_s5[s] == best_d_w && slot_nid[s] < best_nid_w))) begin
				best_hit_w  = 1'b1;
				best_d_w    = tdist_s5[s];
				best_nid_w  = slot_nid[s];
				best_port_w = to_out(slot_port[s]);
			end
		end
	end

	logic             is_me_s6, is_buf_s6, buf_local_s6, hop_hit_s6;
	logic             step_hit_s6, buf_hit_s6, best_hit_s6;
	logic [OUT_W-1:0] hop_port_s6, step_port_s6, buf_port_s6, best_port_s6;

	always_ff @(posedge clk) begin
		if (adv6) begin
			is_me_s6     <= is_me_s5;
			is_buf_s6    <= is_buf_s5;
			buf_local_s6 <= buf_local_s5;
			hop_hit_s6   <= hop_hit_s5;
			hop_port_s6  <= hop_port_s5;
			step_hit_s6  <= step_hit_w;
			step_port_s6 <= step_port_w;
			buf_hit_s6   <= buf_hit_w;
			buf_port_s6  <= buf_port_w;
			best_hit_s6  <= best_hit_w;
			best_port_s6 <= best_port_w;
		end
	end

	// ---------------------------------------------------------------
	// Stage 7: rule priority into the output register
	// ---------------------------------------------------------------
	logic             dead_w;
	logic [OUT_W-1:0] port_w;

	always_comb begin
		dead_w = 1'b0;
		port_w = '0;
		if (is_me_s6) begin
			dead_w = core_port_q[3];
			port_w = core_port_q[OUT_W-1:0];
		end else if (is_buf_s6) begin
			if (buf_local_s6) begin
				dead_w = buffer_port_q[3];
				port_w = buffer_port_q[OUT_W-1:0];
			end else begin
				dead_w = !buf_hit_s6;
				port_w = buf_port_s6;
			end
		end else if (hop_hit_s6) begin
			port_w = hop_port_s6;
		end else if (step_hit_s6) begin
			port_w = step_port_s6;
		end else if (best_hit_s6) begin
			port_w = best_port_s6;
		end else begin
			dead_w = 1'b1;
		end
		// drop the port on a dead end
		if (dead_w)
			port_w = '0;
	end

	logic [OUT_W-1:0] out_port_s7;
	logic             dead_s7;

	always_ff @(posedge clk) begin
		if (adv7) begin
			out_port_s7 <= port_w;
			dead_s7     <= dead_w;
		end
	end

	assign m_tvalid = v_s7;
	assign m_tdata  = M_TDATA_W'(out_port_s7);
	assign m_tuser  = dead_s7;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while the sink is ready");

	a_dead_port_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("dead-end beat carries a nonzero port");

	a_s6_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && !adv7 |=> v_s6)
		else $error("stage 6 beat lost while output stalled");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted beat missing from stage 1");

endmodule
